// File: rtl/bil_pkg.sv
// shared constants, codes and types of the bounded indexed list
package bil_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OPCODE_W   = 2;
  localparam int ITEM_W     = 32;
  localparam int POSITION_W = 5;
  localparam int STATUS_W   = 2;
  localparam int READ_W     = 32;
  localparam int LENGTH_W   = 5;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

  // command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } bil_cmd_e;

endpackage

// File: rtl/bil_cell.sv
// storage cell of the list chain, next word from itself, a neighbor, head or input
module bil_cell #(
  parameter int VALUE_WIDTH = bil_pkg::VALUE_WIDTH_DEF,
  parameter int LEN_W       = $clog2(bil_pkg::CAPACITY_DEF + 1),
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  bil_pkg::bil_cmd_e      cmd_i,
  input  logic [LEN_W-1:0]       pos_i,
  input  logic [LEN_W-1:0]       len_i,
  input  logic [VALUE_WIDTH-1:0] new_value_i,
  input  logic [VALUE_WIDTH-1:0] prev_value_i,
  input  logic [VALUE_WIDTH-1:0] next_value_i,
  input  logic [VALUE_WIDTH-1:0] head_value_i,
  output logic [VALUE_WIDTH-1:0] value_o
);
  import bil_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX    = LEN_W'(INDEX);
  localparam logic [LEN_W-1:0] MY_IDX_P1 = LEN_W'(INDEX + 1);

  logic [VALUE_WIDTH-1:0] value_q;
  logic [VALUE_WIDTH-1:0] value_d;

  always_comb begin
    value_d = value_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (MY_IDX == pos_i) begin
          value_d = new_value_i;
        end else if (MY_IDX > pos_i) begin
          value_d = prev_value_i;
        end
      end
      CMD_REMOVE: begin
        if (MY_IDX >= pos_i) begin
          value_d = next_value_i;
        end
      end
      CMD_ROTATE: begin
        // head word wraps to the last live cell, the ones before it move down
        if (MY_IDX_P1 == len_i) begin
          value_d = head_value_i;
        end else if (MY_IDX_P1 < len_i) begin
          value_d = next_value_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// File: rtl/bounded_indexed_list_top.sv
// top level of the bounded indexed list: control, length counter, cell chain, result register
//
// Ordered list of up to CAPACITY signed words held in a chain of cells, one
// word per cell, with cell 0 at the head. Append, insert and remove are done
// without a serial shift: every cell at or past the edit point takes the new
// word or the word of its neighbor at once, so an edit word is taken whenever
// the result register is free (or is being drained in the same cycle) and its
// one status word is offered on the next cycle. In a dump the list rotates
// through the head cell, one entry per cycle while the output does not stall,
// so the head cell is the only read point and sets that rate; after length
// steps the list is back in its original order. No new input word is taken
// while a dump streams. Status: 0 ok, 1 bad index, 2 full, 3 empty.
// Edit results carry read_value 0 and the length after the edit; every last
// word of a run has last_of_run set. Stored words are the low VALUE_WIDTH
// bits of the sign-extended input and read back zero-extended to 32 bits.
// Entries carry no reset; only slots below the length are ever shown.
module bounded_indexed_list_top #(
  parameter int CAPACITY    = bil_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bil_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [bil_pkg::OPCODE_W-1:0]           opcode_i,
  input  logic signed [bil_pkg::ITEM_W-1:0]      item_value_i,
  input  logic [bil_pkg::POSITION_W-1:0]         position_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [bil_pkg::STATUS_W-1:0]           status_o,
  output logic signed [bil_pkg::READ_W-1:0]      read_value_o,
  output logic [bil_pkg::LENGTH_W-1:0]           list_length_o,
  output logic                                   last_of_run_o
);
  import bil_pkg::*;

  localparam int LEN_W = $clog2(CAPACITY + 1);
  // common width for comparing the requested position with the length
  localparam int CMP_W = (LEN_W > POSITION_W) ? LEN_W : POSITION_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  // control state
  logic             state_q, state_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [READ_W-1:0]   out_value_q, out_value_d;
  logic [LENGTH_W-1:0] out_len_q, out_len_d;
  logic                out_last_q, out_last_d;

  // cell chain
  bil_cmd_e               cmd;
  logic [LEN_W-1:0]       cell_pos;
  logic [VALUE_WIDTH-1:0] new_value;
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
  logic [VALUE_WIDTH-1:0] head_value;

  logic             out_free;
  logic             in_acc;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] len_ext;
  logic [LEN_W-1:0] cnt_inc;
  logic             dump_last;

  // result slot is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_DUMP) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign full      = (len_q == LEN_W'(CAPACITY));
  assign empty     = (len_q == '0);
  assign pos_ext   = CMP_W'(position_i);
  assign len_ext   = CMP_W'(len_q);
  assign cnt_inc   = cnt_q + LEN_W'(1);
  assign dump_last = (cnt_inc == len_q);

  // sign-extend or truncate the 32-bit input to the stored width
  assign new_value  = VALUE_WIDTH'(item_value_i);
  assign head_value = cell_value[0];

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    cmd          = CMD_HOLD;
    cell_pos     = len_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_len_d    = out_len_q;
    out_last_d   = out_last_q;

    if (in_acc) begin
      // edit result defaults: one word, value zero, last of run
      out_value_d = '0;
      out_last_d  = 1'b1;
      case (opcode_i)
        OP_APPEND: begin
          out_valid_d = 1'b1;
          if (full) begin
            out_status_d = STATUS_FULL;
          end else begin
            out_status_d = STATUS_OK;
            cmd          = CMD_INSERT;
            cell_pos     = len_q;
            len_d        = len_q + LEN_W'(1);
          end
        end
        OP_INSERT: begin
          out_valid_d = 1'b1;
          if (pos_ext > len_ext) begin
            out_status_d = STATUS_BAD_INDEX;
          end else if (full) begin
            out_status_d = STATUS_FULL;
          end else begin
            out_status_d = STATUS_OK;
            cmd          = CMD_INSERT;
            cell_pos     = LEN_W'(position_i);
            len_d        = len_q + LEN_W'(1);
          end
        end
        OP_REMOVE: begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_status_d = STATUS_EMPTY;
          end else if (pos_ext >= len_ext) begin
            out_status_d = STATUS_BAD_INDEX;
          end else begin
            out_status_d = STATUS_OK;
            cmd          = CMD_REMOVE;
            cell_pos     = LEN_W'(position_i);
            len_d        = len_q - LEN_W'(1);
          end
        end
        OP_DUMP: begin
          if (empty) begin
            out_valid_d  = 1'b1;
            out_status_d = STATUS_EMPTY;
          end else begin
            // stream starts next cycle from the head cell
            state_d = ST_DUMP;
            cnt_d   = '0;
          end
        end
        default: state_d = state_q;
      endcase
      out_len_d = LENGTH_W'(len_d);
    end else if (state_q == ST_DUMP && out_free) begin
      // show the head word and rotate the live part of the chain by one
      cmd          = CMD_ROTATE;
      out_valid_d  = 1'b1;
      out_status_d = STATUS_OK;
      out_value_d  = READ_W'(head_value);
      out_len_d    = LENGTH_W'(len_q);
      out_last_d   = dump_last;
      cnt_d        = cnt_inc;
      if (dump_last) begin
        state_d = ST_IDLE;
      end
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_value;
    logic [VALUE_WIDTH-1:0] next_value;

    if (i == 0) begin : g_first
      assign prev_value = '0;
    end else begin : g_mid_prev
      assign prev_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_value = '0;
    end else begin : g_mid_next
      assign next_value = cell_value[i+1];
    end

    bil_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .LEN_W       (LEN_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .pos_i        (cell_pos),
      .len_i        (len_q),
      .new_value_i  (new_value),
      .prev_value_i (prev_value),
      .next_value_i (next_value),
      .head_value_i (head_value),
      .value_o      (cell_value[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_len_q    <= out_len_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_value_q;
  assign list_length_o = out_len_q;
  assign last_of_run_o = out_last_q;

  // length stays within the chain
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(CAPACITY))
    else $error("list length beyond capacity");

  // dump counter always points at a live entry
  a_dump_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (cnt_q < len_q))
    else $error("dump counter past length");

  // length only moves on an accepted word
  a_len_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> (len_q == $past(len_q)))
    else $error("length changed without an input word");

  // an accepted edit gives its single closing result on the next cycle
  a_edit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && opcode_i != OP_DUMP) |=> (out_valid_q && out_last_q))
    else $error("edit result missing");

endmodule

// File: tb/bil_checker.sv
// result checker of the bounded indexed list: mirrors the list and compares every result word
`timescale 1ns / 100ps
module bil_checker #(
  parameter int CAPACITY    = bil_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bil_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [bil_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic signed [bil_pkg::ITEM_W-1:0]  item_value_i,
  input  logic [bil_pkg::POSITION_W-1:0]     position_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [bil_pkg::STATUS_W-1:0]       status_i,
  input  logic signed [bil_pkg::READ_W-1:0]  read_value_i,
  input  logic [bil_pkg::LENGTH_W-1:0]       list_length_i,
  input  logic                               last_of_run_i,
  output int                                 mismatch_count_o,
  output int                                 words_due_o,
  output int                                 words_checked_o,
  output int                                 list_length_o
);
  import bil_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [READ_W-1:0]   read_value;
    logic [LENGTH_W-1:0] list_length;
    logic                last_of_run;
  } list_word_t;

  // mirror of the list contents and the result words still owed
  logic [VALUE_WIDTH-1:0] held_values [CAPACITY];
  int                     held_count;
  list_word_t             results_due [$];
  int                     mismatches;
  int                     checked;

  assign mismatch_count_o = mismatches;
  assign words_checked_o  = checked;
  assign list_length_o    = held_count;

  function automatic void owe_word(logic [STATUS_W-1:0] status, logic [READ_W-1:0] value,
                                   logic last);
    list_word_t w;
    w.status      = status;
    w.read_value  = value;
    w.list_length = LENGTH_W'(held_count);
    w.last_of_run = last;
    results_due.push_back(w);
  endfunction

  // apply one accepted word to the mirror and queue the words it causes
  function automatic void apply_list_op(logic [OPCODE_W-1:0] op,
                                        logic signed [ITEM_W-1:0] item,
                                        logic [POSITION_W-1:0] pos);
    logic signed [63:0]     wide;
    logic [VALUE_WIDTH-1:0] stored;
    logic [STATUS_W-1:0]    status;
    int                     p;
    wide   = item;
    stored = wide[VALUE_WIDTH-1:0];
    p      = int'(pos);
    status = STATUS_OK;
    case (op)
      OP_APPEND: begin
        if (held_count >= CAPACITY) begin
          status = STATUS_FULL;
        end else begin
          held_values[held_count] = stored;
          held_count++;
        end
      end
      OP_INSERT: begin
        if (p > held_count) begin
          status = STATUS_BAD_INDEX;
        end else if (held_count >= CAPACITY) begin
          status = STATUS_FULL;
        end else begin
          for (int i = held_count; i > p; i--) held_values[i] = held_values[i-1];
          held_values[p] = stored;
          held_count++;
        end
      end
      OP_REMOVE: begin
        if (held_count == 0) begin
          status = STATUS_EMPTY;
        end else if (p >= held_count) begin
          status = STATUS_BAD_INDEX;
        end else begin
          for (int i = p; i + 1 < held_count; i++) held_values[i] = held_values[i+1];
          held_count--;
        end
      end
      default: begin
        if (held_count == 0) begin
          owe_word(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < held_count; i++)
            owe_word(STATUS_OK, READ_W'(held_values[i]), i == held_count - 1);
        end
      end
    endcase
    if (op != OP_DUMP) owe_word(status, '0, 1'b1);
  endfunction

  function automatic void note_mismatch(string what, list_word_t due, list_word_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: due status %0d value %h length %0d last %0b",
               $time, what, due.status, due.read_value, due.list_length, due.last_of_run);
      $display("%0t: %s: got status %0d value %h length %0d last %0b",
               $time, what, seen.status, seen.read_value, seen.list_length, seen.last_of_run);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    list_word_t seen;
    list_word_t due;
    if (!rst_ni) begin
      held_count = 0;
      results_due.delete();
      mismatches  = 0;
      checked     = 0;
      words_due_o = 0;
    end else begin
      // output first: a word taken this edge is never offered in the same cycle
      if (out_valid_i && !out_stall_i) begin
        seen.status      = status_i;
        seen.read_value  = read_value_i;
        seen.list_length = list_length_i;
        seen.last_of_run = last_of_run_i;
        checked++;
        if (results_due.size() == 0) begin
          note_mismatch("result word with nothing due", '0, seen);
        end else begin
          due = results_due.pop_front();
          if (seen.status !== due.status || seen.read_value !== due.read_value ||
              seen.list_length !== due.list_length || seen.last_of_run !== due.last_of_run)
            note_mismatch("result word differs", due, seen);
        end
      end
      if (in_valid_i && !in_stall_i) apply_list_op(opcode_i, item_value_i, position_i);
      words_due_o = results_due.size();
    end
  end

endmodule

// File: tb/tb.sv
// testbench top of the bounded indexed list: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
  import bil_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_WORDS = 260;
  // cycles with no input word accepted before the run is declared hung;
  // a correct run never waits longer than a full dump under the longest stalls,
  // a sender gap, or the end pause
  localparam int IDLE_LIMIT   = 2000;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [OPCODE_W-1:0]        opcode       = OP_APPEND;
  logic signed [ITEM_W-1:0]   item_value   = '0;
  logic [POSITION_W-1:0]      position     = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic signed [READ_W-1:0]   read_value;
  logic [LENGTH_W-1:0]        list_length;
  logic                       last_of_run;

  int mismatch_count;
  int words_due;
  int words_checked;
  int model_length;

  // when set, neither side inserts gaps or stalls
  bit steady_flow = 1'b0;
  int op_count [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;

  always #6 clk = ~clk;

  bounded_indexed_list_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .item_value_i  (item_value),
    .position_i    (position),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .read_value_o  (read_value),
    .list_length_o (list_length),
    .last_of_run_o (last_of_run)
  );

  bil_checker list_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .opcode_i         (opcode),
    .item_value_i     (item_value),
    .position_i       (position),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .read_value_i     (read_value),
    .list_length_i    (list_length),
    .last_of_run_i    (last_of_run),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due),
    .words_checked_o  (words_checked),
    .list_length_o    (model_length)
  );

  // hang detection: count cycles in which no input word is accepted
  always @(posedge clk) begin
    if (in_valid && !in_stall) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("no input word taken for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: may stall before taking each word, unless steady_flow is set
  initial begin : result_sink
    int hold;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // extremes show up often, the rest is uniform
  function automatic logic signed [ITEM_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // offer one word after a random gap and hold it until it is taken;
  // called and returning at a falling edge
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic signed [ITEM_W-1:0] value,
                           input logic [POSITION_W-1:0] pos);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode     = op;
    item_value = value;
    position   = pos;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    op_count[op]++;
  endtask

  // sender holds off until every owed result word has come back
  task automatic drain_results();
    in_valid = 1'b0;
    while (words_due != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    int                  len;
    int                  grow_pct;
    logic [OPCODE_W-1:0] op;
    logic [POSITION_W-1:0] pos;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty list corner cases
    send_word(OP_DUMP, pick_value(), 5'd31);          // dump of empty list
    send_word(OP_REMOVE, pick_value(), 5'd31);        // empty wins over bad index
    send_word(OP_INSERT, 32'sh5a5a_5a5a, 5'd1);       // past the end of an empty list
    // build up with extreme values, head, middle and tail inserts
    send_word(OP_INSERT, 32'sh8000_0000, 5'd0);
    send_word(OP_APPEND, 32'sh7fff_ffff, 5'd0);
    send_word(OP_INSERT, '0, 5'd1);
    send_word(OP_INSERT, -1, 5'd3);
    send_word(OP_INSERT, 32'sh0000_0001, 5'd0);
    while (model_length < CAP)
      send_word(OP_APPEND, $urandom, POSITION_W'($urandom_range(0, 31)));
    // full list: append, insert in range, insert past the end, insert at the end
    send_word(OP_APPEND, pick_value(), 5'd0);
    send_word(OP_INSERT, pick_value(), 5'd7);
    send_word(OP_INSERT, pick_value(), 5'd17);
    send_word(OP_INSERT, pick_value(), 5'd16);
    send_word(OP_DUMP, pick_value(), 5'd0);
    drain_results();
    // removes: one past the end, head, tail, middle
    send_word(OP_REMOVE, pick_value(), 5'd16);
    send_word(OP_REMOVE, pick_value(), 5'd0);
    send_word(OP_REMOVE, pick_value(), 5'd14);
    send_word(OP_REMOVE, pick_value(), 5'd6);

    // random: mostly in-range indexes so the list wanders between empty and full,
    // with trends that alternate between filling and draining
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady_flow = (n >= 100 && n < 140);
      if (n == 180) drain_results();
      grow_pct = (n % 80 < 40) ? 70 : 30;
      len = model_length;
      if ($urandom_range(0, 99) < 10) op = OP_DUMP;
      else if ($urandom_range(0, 99) < grow_pct) op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
      else op = OP_REMOVE;
      pos = POSITION_W'($urandom_range(0, 31));
      // about one in seven keeps a fully random index as noise
      if ($urandom_range(0, 99) < 85) begin
        if (op == OP_INSERT) pos = POSITION_W'($urandom_range(0, len));
        else if (op == OP_REMOVE && len > 0) pos = POSITION_W'($urandom_range(0, len - 1));
      end
      send_word(op, pick_value(), pos);
    end
    steady_flow = 1'b0;

    // end: wait out every owed word, then give the block time to misbehave
    drain_results();
    repeat (20) @(negedge clk);

    $display("sent %0d words: %0d append, %0d insert, %0d remove, %0d dump",
             op_count[0] + op_count[1] + op_count[2] + op_count[3],
             op_count[OP_APPEND], op_count[OP_INSERT], op_count[OP_REMOVE], op_count[OP_DUMP]);
    $display("checked %0d result words, %0d mismatches, %0d still owed",
             words_checked, mismatch_count, words_due);
    if (mismatch_count == 0 && words_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/bil_pkg.sv
rtl/bil_cell.sv
rtl/bounded_indexed_list_top.sv
tb/bil_checker.sv
tb/tb.sv
